// ----- sv/ucdp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucdp_pkg
// Types and constants for the USB configuration descriptor parser.
// ----------------------------------------------------------------------------
package ucdp_pkg;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    // register word index (paddr[2])
    localparam logic REG_DATA_IFACE_FILTER = 1'b0;

    localparam logic [7:0] FILTER_RESET   = 8'd1;
    localparam logic [7:0] TYPE_INTERFACE = 8'h04;
    localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
    localparam logic [7:0] CLASS_CONTROL  = 8'h02;
    localparam logic [7:0] CLASS_DATA     = 8'h0A;
    localparam logic [1:0] XFER_BULK      = 2'b10;
    localparam logic [7:0] IFACE_NONE     = 8'hFF;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;

    localparam logic [7:0] POS_TYPE   = 8'd1;
    localparam logic [7:0] POS_CAP2   = 8'd2;
    localparam logic [7:0] POS_CAP3   = 8'd3;
    localparam logic [7:0] POS_CAP4   = 8'd4;
    localparam logic [7:0] POS_DECIDE = 8'd5;

    // findings reported on the last byte
    typedef struct packed {
        logic [7:0]  found_count;
        logic [7:0]  control_iface;
        logic [7:0]  data_iface;
        logic [6:0]  bulk_in_number;
        logic [7:0]  bulk_out_address;
        logic [15:0] bulk_in_packet_max;
        logic [15:0] bulk_out_packet_max;
    } result_t;

    // walker state
    typedef struct packed {
        logic [7:0] pos;
        logic [7:0] len;
        logic [7:0] dtype;
        logic [7:0] cap2;
        logic [7:0] cap3;
        logic [7:0] cap4;
        logic       stopped;
        logic [7:0] cur_iface;
        logic [7:0] cur_class;
    } walk_t;

    localparam walk_t WALK_RESET = '{
        pos: 8'd0, len: 8'd0, dtype: 8'd0, cap2: 8'd0, cap3: 8'd0, cap4: 8'd0,
        stopped: 1'b0, cur_iface: IFACE_NONE, cur_class: 8'd0
    };

endpackage
`default_nettype wire

// ----- sv/usb_cdc_config_descriptor_parser_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A last_byte word's result is registered into the result buffer. Throughput: one
// byte per cycle while in_ready is high; the walker updates in a single registered
// step. A two-entry result buffer (output register plus skid) keeps in_ready high
// while one result waits; in_ready falls only when both entries hold results.
// Reset (rst_n low, async): walker cleared, results empty, filter back to 1.
// ----------------------------------------------------------------------------
// usb_cdc_config_descriptor_parser_top
// Walks a configuration descriptor byte stream and reports CDC interfaces and
// bulk endpoints of the selected data interface at the end of the stream.
// ----------------------------------------------------------------------------
module usb_cdc_config_descriptor_parser_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // APB config
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ucdp_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ucdp_pkg::DATA_W-1:0]  pwdata,
    output logic      [ucdp_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    // byte stream
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [7:0]                   data_byte,
    input  wire logic                         last_byte,
    // results
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [7:0]                        found_count,
    output logic [7:0]                        control_iface,
    output logic [7:0]                        data_iface,
    output logic [6:0]                        bulk_in_number,
    output logic [7:0]                        bulk_out_address,
    output logic [15:0]                       bulk_in_packet_max,
    output logic [15:0]                       bulk_out_packet_max
);

    logic [7:0]        filter_reg;
    ucdp_pkg::walk_t   walk_reg, walk_next, walk_step;
    ucdp_pkg::result_t find_reg, find_next, find_step;
    ucdp_pkg::result_t out_reg, out_next, skid_reg, skid_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    logic       in_fire, push, out_fire;
    logic [7:0] pos_inc, len_eff;
    logic [7:0] count_inc;

    // ---------------- config port ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= ucdp_pkg::FILTER_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == ucdp_pkg::REG_DATA_IFACE_FILTER))
        begin
            filter_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == ucdp_pkg::REG_DATA_IFACE_FILTER)
        begin
            prdata = {{(ucdp_pkg::DATA_W-8){1'b0}}, filter_reg};
        end
    end

    // ---------------- handshake ----------------
    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign push     = in_fire && last_byte;
    assign out_fire = out_valid_reg && out_ready;

    // ---------------- descriptor walker ----------------
    assign count_inc = (find_reg.found_count == ucdp_pkg::COUNT_MAX) ?
                       find_reg.found_count : find_reg.found_count + 8'd1;
    assign pos_inc   = walk_reg.pos + 8'd1;
    assign len_eff   = (walk_reg.pos == 8'd0) ? data_byte : walk_reg.len;

    always_comb
    begin
        walk_step = walk_reg;
        find_step = find_reg;
        if (!walk_reg.stopped)
        begin
            if (walk_reg.pos == 8'd0)
            begin
                walk_step.len = data_byte;
            end
            case (walk_reg.pos)
                ucdp_pkg::POS_TYPE: walk_step.dtype = data_byte;
                ucdp_pkg::POS_CAP2: walk_step.cap2  = data_byte;
                ucdp_pkg::POS_CAP3: walk_step.cap3  = data_byte;
                ucdp_pkg::POS_CAP4: walk_step.cap4  = data_byte;
                ucdp_pkg::POS_DECIDE:
                begin
                    if (walk_reg.dtype == ucdp_pkg::TYPE_INTERFACE)
                    begin
                        walk_step.cur_iface = walk_reg.cap2;
                        walk_step.cur_class = data_byte;
                        if (data_byte == ucdp_pkg::CLASS_CONTROL)
                        begin
                            find_step.control_iface = walk_reg.cap2;
                            find_step.found_count   = count_inc;
                        end
                        else if (data_byte == ucdp_pkg::CLASS_DATA)
                        begin
                            find_step.data_iface  = walk_reg.cap2;
                            find_step.found_count = count_inc;
                        end
                    end
                    else if (walk_reg.dtype == ucdp_pkg::TYPE_ENDPOINT
                             && walk_reg.cur_iface == filter_reg
                             && walk_reg.cur_class == ucdp_pkg::CLASS_DATA
                             && walk_reg.cap3[1:0] == ucdp_pkg::XFER_BULK)
                    begin
                        if (walk_reg.cap2[7])
                        begin
                            find_step.bulk_in_number     = walk_reg.cap2[6:0];
                            find_step.bulk_in_packet_max = {data_byte, walk_reg.cap4};
                        end
                        else
                        begin
                            find_step.bulk_out_address    = walk_reg.cap2;
                            find_step.bulk_out_packet_max = {data_byte, walk_reg.cap4};
                        end
                        find_step.found_count = count_inc;
                    end
                end
                default: ;
            endcase
            // zero length byte halts the walk until the end of stream
            if (walk_reg.pos == 8'd0 && data_byte == 8'd0)
            begin
                walk_step.stopped = 1'b1;
            end
            else
            begin
                walk_step.pos = (pos_inc >= len_eff) ? 8'd0 : pos_inc;
            end
        end
    end

    always_comb
    begin
        walk_next = walk_reg;
        find_next = find_reg;
        if (in_fire)
        begin
            if (last_byte)
            begin
                walk_next = ucdp_pkg::WALK_RESET;
                find_next = '0;
            end
            else
            begin
                walk_next = walk_step;
                find_next = find_step;
            end
        end
    end

    // ---------------- result buffer ----------------
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = find_step;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = find_step;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg       <= ucdp_pkg::WALK_RESET;
            find_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            walk_reg       <= walk_next;
            find_reg       <= find_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid           = out_valid_reg;
    assign found_count         = out_reg.found_count;
    assign control_iface       = out_reg.control_iface;
    assign data_iface          = out_reg.data_iface;
    assign bulk_in_number      = out_reg.bulk_in_number;
    assign bulk_out_address    = out_reg.bulk_out_address;
    assign bulk_in_packet_max  = out_reg.bulk_in_packet_max;
    assign bulk_out_packet_max = out_reg.bulk_out_packet_max;

endmodule
`default_nettype wire

// ----- sv/ucdp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucdp_checker
// Port-level checks for the descriptor parser, bound to the top level.
// ----------------------------------------------------------------------------
module ucdp_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         psel,
    input wire logic                         penable,
    input wire logic                         pwrite,
    input wire logic [ucdp_pkg::ADDR_W-1:0]  paddr,
    input wire logic [ucdp_pkg::DATA_W-1:0]  pwdata,
    input wire logic [ucdp_pkg::DATA_W-1:0]  prdata,
    input wire logic                         pready,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic [7:0]                   data_byte,
    input wire logic                         last_byte,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [7:0]                   found_count,
    input wire logic [7:0]                   control_iface,
    input wire logic [7:0]                   data_iface,
    input wire logic [6:0]                   bulk_in_number,
    input wire logic [7:0]                   bulk_out_address,
    input wire logic [15:0]                  bulk_in_packet_max,
    input wire logic [15:0]                  bulk_out_packet_max
);

    // a held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found_count)
                                    && $stable(bulk_in_packet_max))
        else $error("result word changed while stalled");

    // input backpressure only when a result is already waiting
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with no pending result");

    // nothing recorded without a count
    a_zero_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found_count == 8'd0 |->
            control_iface == 8'd0 && data_iface == 8'd0 && bulk_in_number == 7'd0
            && bulk_out_address == 8'd0 && bulk_in_packet_max == 16'd0
            && bulk_out_packet_max == 16'd0)
        else $error("finding reported with zero count");

    // a last byte taken while no result waits shows a result next cycle
    a_empty_stream: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_byte && !out_valid |=> out_valid)
        else $error("last byte gave no result");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind usb_cdc_config_descriptor_parser_top ucdp_checker u_ucdp_checker (.*);
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the USB CDC configuration descriptor parser. Feeds
// descriptor byte streams (directed, well-formed random, truncated and noise)
// under random sender/receiver gaps, predicts the findings reported on each
// last byte and compares them field by field. The filter register is swept
// through reset value, 0, 255 and a random value.
// ----------------------------------------------------------------------------
module tb_top;
    import ucdp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [7:0]  TYPE_CONFIG = 8'h02;

    // ------------------------------------------------------------------------
    // findings predictor and result checker
    // ------------------------------------------------------------------------
    class descriptor_scoreboard;
        logic [7:0] filter;
        logic [7:0] pos, len, dtype, cap2, cap3, cap4, cur_iface, cur_class;
        bit         stopped;
        result_t    findings;
        result_t    expected_q[$];
        int         errors;
        int         checked;

        function new();
            filter = FILTER_RESET;
            errors = 0;
            checked = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            pos = 0;
            len = 0;
            dtype = 0;
            cap2 = 0;
            cap3 = 0;
            cap4 = 0;
            stopped = 0;
            cur_iface = IFACE_NONE;
            cur_class = 0;
            findings = '0;
        endfunction

        function void bump_count();
            if (findings.found_count != COUNT_MAX)
                findings.found_count = findings.found_count + 8'd1;
        endfunction

        // offset 5 reached: descriptor is complete enough to act on
        function void decide(logic [7:0] b5);
            if (dtype == TYPE_INTERFACE)
            begin
                cur_iface = cap2;
                cur_class = b5;
                if (b5 == CLASS_CONTROL)
                begin
                    findings.control_iface = cap2;
                    bump_count();
                end
                else if (b5 == CLASS_DATA)
                begin
                    findings.data_iface = cap2;
                    bump_count();
                end
            end
            else if (dtype == TYPE_ENDPOINT && cur_iface == filter && cur_class == CLASS_DATA
                     && cap3[1:0] == XFER_BULK)
            begin
                if (cap2[7])
                begin
                    findings.bulk_in_number = cap2[6:0];
                    findings.bulk_in_packet_max = {b5, cap4};
                end
                else
                begin
                    findings.bulk_out_address = cap2;
                    findings.bulk_out_packet_max = {b5, cap4};
                end
                bump_count();
            end
        endfunction

        function void note_byte(logic [7:0] b, bit is_last);
            if (!stopped)
            begin
                if (pos == 0)
                begin
                    len = b;
                    if (b == 0)
                        stopped = 1;
                end
                else
                begin
                    case (pos)
                        POS_TYPE:   dtype = b;
                        POS_CAP2:   cap2 = b;
                        POS_CAP3:   cap3 = b;
                        POS_CAP4:   cap4 = b;
                        POS_DECIDE: decide(b);
                        default:    ;
                    endcase
                end
                if (!stopped)
                begin
                    pos = pos + 8'd1;
                    if (pos >= len)
                        pos = 0;
                end
            end
            if (is_last)
            begin
                expected_q.push_back(findings);
                clear_walk();
            end
        endfunction

        function void diff(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result word with nothing outstanding");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            diff("found_count", want.found_count, got.found_count);
            diff("control_iface", want.control_iface, got.control_iface);
            diff("data_iface", want.data_iface, got.data_iface);
            diff("bulk_in_number", want.bulk_in_number, got.bulk_in_number);
            diff("bulk_out_address", want.bulk_out_address, got.bulk_out_address);
            diff("bulk_in_packet_max", want.bulk_in_packet_max, got.bulk_in_packet_max);
            diff("bulk_out_packet_max", want.bulk_out_packet_max, got.bulk_out_packet_max);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                clk;
    logic                rst_n;
    logic                psel, penable, pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid, in_ready;
    logic [7:0]          data_byte;
    logic                last_byte;
    logic                out_valid, out_ready;
    logic [7:0]          found_count, control_iface, data_iface, bulk_out_address;
    logic [6:0]          bulk_in_number;
    logic [15:0]         bulk_in_packet_max, bulk_out_packet_max;

    descriptor_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_req = 0;
    int          hold_left = 0;
    int          holds_done = 0;
    int unsigned cycles = 0;
    int          bytes_sent = 0;
    int          streams_sent = 0;
    int          cfg_errors = 0;
    logic [7:0]  filter_now = FILTER_RESET;
    logic [7:0]  stream_q[$];

    usb_cdc_config_descriptor_parser_top dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .data_byte           (data_byte),
        .last_byte           (last_byte),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .found_count         (found_count),
        .control_iface       (control_iface),
        .data_iface          (data_iface),
        .bulk_in_number      (bulk_in_number),
        .bulk_out_address    (bulk_out_address),
        .bulk_in_packet_max  (bulk_in_packet_max),
        .bulk_out_packet_max (bulk_out_packet_max)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("usb_cdc_config_descriptor_parser_top regression: fail");
        $finish;
    end

    // result side: check accepted words, then pick next out_ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{found_count, control_iface, data_iface, bulk_in_number,
                              bulk_out_address, bulk_in_packet_max, bulk_out_packet_max});
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req = 0;
            hold_left = 120;
            holds_done++;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic push_byte(logic [7:0] b, bit is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++)
            push_byte(stream_q[i], i == stream_q.size() - 1);
        streams_sent++;
    endtask

    // drop valid, wait for all findings, then let the walker settle
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_filter(logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DATA_IFACE_FILTER, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.filter  = value;
        filter_now = value;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[7:0] !== value)
        begin
            $error("data_iface_filter readback: expected 0x%0h, got 0x%0h", value, prdata[7:0]);
            cfg_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // stream builders
    // ------------------------------------------------------------------------
    // pushes the first len bytes of a descriptor; len 0 pushes just the zero
    function automatic void add_desc(int len, logic [7:0] dtype, logic [7:0] b2,
                                     logic [7:0] b3, logic [7:0] b4, logic [7:0] b5);
        logic [7:0] head [6];
        int         n;
        head = '{8'(len), dtype, b2, b3, b4, b5};
        n = (len == 0) ? 1 : len;
        for (int i = 0; i < n; i++)
            stream_q.push_back(i < 6 ? head[i] : 8'($urandom_range(255)));
    endfunction

    function automatic logic [7:0] pick_iface();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return filter_now;
        if (r < 65)
            return 8'h00;
        if (r < 75)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_class();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return CLASS_DATA;
        if (r < 75)
            return CLASS_CONTROL;
        return 8'($urandom_range(255));
    endfunction

    function automatic void add_random_desc();
        int         r;
        logic [1:0] xfer;
        r = $urandom_range(99);
        xfer = ($urandom_range(99) < 80) ? XFER_BULK : 2'($urandom_range(3));
        if (r < 30)
            add_desc($urandom_range(6, 9), TYPE_INTERFACE, pick_iface(),
                     8'($urandom_range(255)), 8'($urandom_range(255)), pick_class());
        else if (r < 75)
            add_desc($urandom_range(6, 7), TYPE_ENDPOINT, 8'($urandom_range(255)),
                     {6'($urandom_range(63)), xfer}, 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        else if (r < 86)
            add_desc($urandom_range(1, 5), $urandom_range(1) ? TYPE_INTERFACE : TYPE_ENDPOINT,
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), CLASS_DATA);
        else if (r < 89)
            add_desc(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        else
            add_desc($urandom_range(2, 12), 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
    endfunction

    function automatic void build_random_stream();
        int n;
        stream_q.delete();
        if ($urandom_range(99) < 12)
        begin
            n = $urandom_range(1, 8);
            repeat (n) stream_q.push_back(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(1))
            add_desc(9, TYPE_CONFIG, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)));
        if ($urandom_range(99) < 60)
            add_desc($urandom_range(6, 9), TYPE_INTERFACE, filter_now,
                     8'($urandom_range(255)), 8'($urandom_range(255)), CLASS_DATA);
        n = $urandom_range(1, 5);
        repeat (n) add_random_desc();
        // cut off somewhere, possibly mid-descriptor
        if ($urandom_range(99) < 15 && stream_q.size() > 1)
        begin
            n = $urandom_range(1, stream_q.size() - 1);
            while (stream_q.size() > n)
                void'(stream_q.pop_back());
        end
    endfunction

    task automatic run_random_phase(int min_bytes, int min_streams);
        int start_bytes;
        int start_streams;
        start_bytes = bytes_sent;
        start_streams = streams_sent;
        while (bytes_sent - start_bytes < min_bytes || streams_sent - start_streams < min_streams)
        begin
            build_random_stream();
            send_stream();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        data_byte <= 8'h00;
        last_byte <= 1'b0;
        out_ready <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 17;
        recv_idle_pct = 57;

        // zero length stops parsing; last byte still reports
        stream_q = '{8'h00, 8'hFF};
        send_stream();
        // lone byte that is both a length and the last byte
        stream_q = '{8'hFF};
        send_stream();
        // length-one descriptor, then data iface with bulk IN and OUT
        stream_q.delete();
        add_desc(1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_desc(6, TYPE_INTERFACE, filter_now, 8'h00, 8'h00, CLASS_DATA);
        add_desc(6, TYPE_ENDPOINT, 8'h81, {6'd0, XFER_BULK}, 8'h40, 8'h00);
        add_desc(6, TYPE_ENDPOINT, 8'h02, {6'd0, XFER_BULK}, 8'h00, 8'h02);
        send_stream();
        // interface cut off by the last byte before its class
        stream_q = '{8'h09, TYPE_INTERFACE, 8'h03, 8'h00, 8'h00};
        send_stream();

        // long output stall while single-byte streams keep coming
        hold_req = 1;
        repeat (12)
        begin
            stream_q = '{8'($urandom_range(255))};
            send_stream();
        end

        run_random_phase(110, 4);
        settle();

        write_filter(8'h00);
        send_idle_pct = 57;
        recv_idle_pct = 17;
        run_random_phase(110, 4);
        settle();

        write_filter(8'hFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(110, 4);
        settle();

        write_filter(8'($urandom_range(255)));
        run_random_phase(110, 4);
        settle();
        repeat (10) @(posedge clk);

        $display("covered %0d bytes in %0d streams, %0d result words checked",
                 bytes_sent, streams_sent, sb.checked);
        $display("filter swept over reset/0/255/random, %0d long output stalls", holds_done);
        if (sb.errors == 0 && cfg_errors == 0 && sb.expected_q.size() == 0)
            $display("usb_cdc_config_descriptor_parser_top regression: pass");
        else
            $display("usb_cdc_config_descriptor_parser_top regression: fail");
        $finish;
    end

endmodule
